@@ hw/rtl/gdwa_pkg.sv @@
// Package for the genotype dosage weighted accumulator.
// Holds the shared types, item kinds, genotype codes and the saturating adder.
// No dependencies.
package gdwa_pkg;

    localparam int ACC_W     = 48;
    localparam int WGT_W     = 32;
    localparam int DELTA_W   = WGT_W + 2;
    localparam int CNT_W     = 13;
    localparam int NUM_LANES = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [WGT_W-1:0]   t_wgt;
    typedef logic signed [DELTA_W-1:0] t_delta;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_GENO   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Homozygous code counts two copies, heterozygous one; others add nothing.
    localparam logic [1:0] GT_HOM = 2'b00;
    localparam logic [1:0] GT_HET = 2'b10;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Per-lane operation for the item in the update stage.
    typedef struct packed {
        logic add;      // accumulate the weights
        logic dbl;      // dosage two instead of one
        logic clr_one;  // zero one column after a read
    } t_lane_op;

    function automatic t_delta scale_weight(input t_wgt w, input logic dbl);
        t_delta d;
        if (dbl) begin
            d = {w[WGT_W-1], w, 1'b0};
        end else begin
            d = {{2{w[WGT_W-1]}}, w};
        end
        return d;
    endfunction

    function automatic t_acc sat_add(input t_acc acc, input t_delta delta);
        logic signed [ACC_W:0] s;
        t_acc r;
        s = {acc[ACC_W-1], acc} + (ACC_W+1)'(delta);
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/gdwa_if.sv @@
// Channel interfaces of the genotype dosage weighted accumulator.
// Depends on gdwa_pkg for field widths.
interface gdwa_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [9:0]                byte_index;
    logic [7:0]                genotype_byte;
    logic [1:0]                column;
    logic signed [31:0]        weight;
    logic [11:0]               subject;
    logic                      clear_after_read;

    modport source (output valid, kind, byte_index, genotype_byte, column, weight,
                    subject, clear_after_read, input ready);
    modport sink   (input valid, kind, byte_index, genotype_byte, column, weight,
                    subject, clear_after_read, output ready);
endinterface

interface gdwa_out_if;
    logic              valid;
    logic              ready;
    gdwa_pkg::t_acc    score_sum;

    modport source (output valid, score_sum, input ready);
    modport sink   (input valid, score_sum, output ready);
endinterface

@@ hw/rtl/gdwa_bank.sv @@
// One accumulator bank: simple dual-port memory with a registered read.
// Depends on gdwa_pkg for the accumulator type.
module gdwa_bank #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  gdwa_pkg::t_acc    i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output gdwa_pkg::t_acc    o_rdata
);

    gdwa_pkg::t_acc r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hw/rtl/gdwa_lane.sv @@
// One subject lane: a bank per weight column, forwarding of the last write,
// and the saturating update. Depends on gdwa_pkg and gdwa_bank.
module gdwa_lane #(
    parameter int NUM_COLUMNS = 4,
    parameter int ROWS        = 1024,
    parameter int ROW_W       = 10,
    parameter int COL_W       = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [ROW_W-1:0]     i_rd_addr,
    input  gdwa_pkg::t_lane_op   i_op,
    input  logic [COL_W-1:0]     i_col,
    input  gdwa_pkg::t_wgt       i_weights [NUM_COLUMNS],
    input  logic                 i_sweep,
    input  logic [ROW_W-1:0]     i_sweep_row,
    output gdwa_pkg::t_acc       o_acc [NUM_COLUMNS]
);

    gdwa_pkg::t_acc           rd_data   [NUM_COLUMNS];
    gdwa_pkg::t_acc           r_wb_data [NUM_COLUMNS];
    gdwa_pkg::t_acc           n_wdata   [NUM_COLUMNS];
    gdwa_pkg::t_acc           cur       [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0]   r_wb_we;
    logic [NUM_COLUMNS-1:0]   n_we;
    logic [ROW_W-1:0]         r_addr;
    logic [ROW_W-1:0]         r_wb_addr;
    logic [ROW_W-1:0]         wr_addr;

    assign wr_addr = i_sweep ? i_sweep_row : r_addr;

    // The bank read of the next item happens at the edge that writes this one,
    // so the value just written is taken from the write-back register.
    always_comb begin
        for (int k = 0; k < NUM_COLUMNS; k++) begin
            cur[k] = (r_wb_we[k] && (r_wb_addr == r_addr)) ? r_wb_data[k] : rd_data[k];
            o_acc[k] = cur[k];
            if (i_sweep) begin
                n_we[k]    = 1'b1;
                n_wdata[k] = '0;
            end else if (i_op.add) begin
                n_we[k]    = 1'b1;
                n_wdata[k] = gdwa_pkg::sat_add(cur[k],
                                 gdwa_pkg::scale_weight(i_weights[k], i_op.dbl));
            end else if (i_op.clr_one && (i_col == COL_W'(k))) begin
                n_we[k]    = 1'b1;
                n_wdata[k] = '0;
            end else begin
                n_we[k]    = 1'b0;
                n_wdata[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_we <= '0;
        end else begin
            r_wb_we <= n_we;
        end
        r_wb_addr <= wr_addr;
        for (int k = 0; k < NUM_COLUMNS; k++) begin
            r_wb_data[k] <= n_wdata[k];
        end
        if (i_rd_en) begin
            r_addr <= i_rd_addr;
        end
    end

    for (genvar k = 0; k < NUM_COLUMNS; k++) begin : g_bank
        gdwa_bank #(
            .DEPTH  (ROWS),
            .ADDR_W (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (n_we[k]),
            .i_waddr (wr_addr),
            .i_wdata (n_wdata[k]),
            .i_re    (i_rd_en),
            .i_raddr (i_rd_addr),
            .o_rdata (rd_data[k])
        );
    end

endmodule

@@ hw/rtl/gdwa_out_fifo.sv @@
// Result queue that parts the update stage from the output channel.
// Depends on gdwa_pkg and the gdwa_out_if interface.
module gdwa_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  gdwa_pkg::t_acc                     i_data,
    output logic [gdwa_pkg::OUT_CNT_W-1:0]     o_count,
    gdwa_out_if.source                         o_out
);

    gdwa_pkg::t_acc                    r_mem [gdwa_pkg::OUT_DEPTH];
    logic [gdwa_pkg::OUT_PTR_W-1:0]    r_wr_ptr;
    logic [gdwa_pkg::OUT_PTR_W-1:0]    r_rd_ptr;
    logic [gdwa_pkg::OUT_CNT_W-1:0]    r_count;
    logic                              pop;

    assign pop             = o_out.valid && o_out.ready;
    assign o_out.valid     = (r_count != '0);
    assign o_out.score_sum = r_mem[r_rd_ptr];
    assign o_count         = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/genotype_dosage_weighted_accumulate.sv @@
// Top level of the genotype dosage weighted accumulator.
// Depends on gdwa_pkg, gdwa_if, gdwa_lane and gdwa_out_fifo.
//
//   Channel   Dir  Beat contents
//   i_in      in   kind, byte_index, genotype_byte, column, weight, subject,
//                  clear_after_read
//   o_out     out  score_sum (one beat per read item)
//   i_cfg_*   in   subject_count, written whenever i_cfg_we is high
//
// One input beat is taken every cycle while i_in.ready is high; a genotype
// byte updates its four subjects in all weight columns at once, and the rate
// is set by the single read-modify-write per bank and cycle, closed by one-deep
// write forwarding. A read result enters the output queue in the cycle after
// its beat is taken and is shown on o_out once older results have left.
// After reset a clearing pass zeroes all min(ceil(MAX_SUBJECTS/4), 1024) bank
// rows (1024 by default), one row per cycle; i_in.ready is low meanwhile. A
// stalled o_out holds off i_in once the queued results plus a read in the
// update stage fill the four queue entries.
module genotype_dosage_weighted_accumulate #(
    parameter int MAX_SUBJECTS = 4096,
    parameter int NUM_COLUMNS  = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gdwa_pkg::CNT_W-1:0]   i_cfg_wdata,
    gdwa_in_if.sink                      i_in,
    gdwa_out_if.source                   o_out
);

    // Byte indexes reach only 1024 rows, so deeper banks would never be used.
    localparam int ROWS_RAW = (MAX_SUBJECTS + gdwa_pkg::NUM_LANES - 1) / gdwa_pkg::NUM_LANES;
    localparam int ROWS     = (ROWS_RAW > 1024) ? 1024 : ROWS_RAW;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W    = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    // Configuration and weights.
    logic [gdwa_pkg::CNT_W-1:0]  r_subject_count;
    gdwa_pkg::t_wgt              r_weights [NUM_COLUMNS];

    // Clearing pass.
    logic                        r_clr_busy;
    logic [ROW_W-1:0]            r_clr_row;

    // Update stage: the item whose bank data arrives this cycle.
    logic                        r_s1_valid;
    logic [1:0]                  r_s1_kind;
    logic [9:0]                  r_s1_byte_index;
    logic [7:0]                  r_s1_gbyte;
    logic [1:0]                  r_s1_column;
    logic [11:0]                 r_s1_subject;
    logic                        r_s1_clear;

    logic                        accept;
    logic [ROW_W-1:0]            rd_addr;
    logic                        s1_push;
    logic                        rd_ok;
    gdwa_pkg::t_acc              read_val;
    gdwa_pkg::t_lane_op          lane_op  [gdwa_pkg::NUM_LANES];
    gdwa_pkg::t_acc              lane_acc [gdwa_pkg::NUM_LANES][NUM_COLUMNS];
    logic [gdwa_pkg::OUT_CNT_W-1:0] fifo_count;
    logic [gdwa_pkg::OUT_CNT_W:0]   pending;

    assign accept = i_in.valid && i_in.ready;

    // Results still to be queued plus those queued must leave room for one more
    // beat, which reaches the queue in the cycle after it is taken.
    assign s1_push    = r_s1_valid && (r_s1_kind == gdwa_pkg::KIND_READ);
    assign pending    = {1'b0, fifo_count} + {{gdwa_pkg::OUT_CNT_W{1'b0}}, s1_push};
    assign i_in.ready = !r_clr_busy
                     && (pending < (gdwa_pkg::OUT_CNT_W+1)'(gdwa_pkg::OUT_DEPTH));

    // A read looks up row subject/4; a genotype byte its byte_index row.
    assign rd_addr = (i_in.kind == gdwa_pkg::KIND_READ) ? ROW_W'(i_in.subject[11:2])
                                                       : ROW_W'(i_in.byte_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subject_count <= gdwa_pkg::CNT_W'(4096);
            r_clr_busy      <= 1'b1;
            r_clr_row       <= '0;
            r_s1_valid      <= 1'b0;
            for (int k = 0; k < NUM_COLUMNS; k++) begin
                r_weights[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_subject_count <= i_cfg_wdata;
            end
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_valid <= accept;
            // Weights change at the accepting edge; an earlier genotype beat
            // in the update stage still sees the old ones.
            if (accept && (i_in.kind == gdwa_pkg::KIND_WEIGHT)) begin
                for (int k = 0; k < NUM_COLUMNS; k++) begin
                    if (32'(i_in.column) == 32'(k)) begin
                        r_weights[k] <= i_in.weight;
                    end
                end
            end
        end
        if (accept) begin
            r_s1_kind       <= i_in.kind;
            r_s1_byte_index <= i_in.byte_index;
            r_s1_gbyte      <= i_in.genotype_byte;
            r_s1_column     <= i_in.column;
            r_s1_subject    <= i_in.subject;
            r_s1_clear      <= i_in.clear_after_read;
        end
    end

    assign rd_ok = (32'(r_s1_column) < 32'(NUM_COLUMNS))
                && ({20'd0, r_s1_subject} < 32'(MAX_SUBJECTS));

    // Lane operations. Subjects past the configured count or the storage
    // limit are skipped; missing and the other unused code add nothing.
    always_comb begin
        logic [11:0] subj;
        logic [1:0]  code;
        logic        live;
        for (int p = 0; p < gdwa_pkg::NUM_LANES; p++) begin
            subj = {r_s1_byte_index, 2'(p)};
            code = r_s1_gbyte[2*p +: 2];
            live = ({1'b0, subj} < r_subject_count)
                && ({20'd0, subj} < 32'(MAX_SUBJECTS));
            lane_op[p].add = r_s1_valid && (r_s1_kind == gdwa_pkg::KIND_GENO) && live
                          && ((code == gdwa_pkg::GT_HOM) || (code == gdwa_pkg::GT_HET));
            lane_op[p].dbl = (code == gdwa_pkg::GT_HOM);
            lane_op[p].clr_one = s1_push && r_s1_clear && rd_ok
                              && (r_s1_subject[1:0] == 2'(p));
        end
    end

    // Merge: pick the addressed lane and column for a read result.
    always_comb begin
        read_val = '0;
        for (int p = 0; p < gdwa_pkg::NUM_LANES; p++) begin
            for (int k = 0; k < NUM_COLUMNS; k++) begin
                if (rd_ok && (r_s1_subject[1:0] == 2'(p))
                          && (32'(r_s1_column) == 32'(k))) begin
                    read_val = lane_acc[p][k];
                end
            end
        end
    end

    for (genvar p = 0; p < gdwa_pkg::NUM_LANES; p++) begin : g_lane
        gdwa_lane #(
            .NUM_COLUMNS (NUM_COLUMNS),
            .ROWS        (ROWS),
            .ROW_W       (ROW_W),
            .COL_W       (COL_W)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_rd_en     (accept),
            .i_rd_addr   (rd_addr),
            .i_op        (lane_op[p]),
            .i_col       (COL_W'(r_s1_column)),
            .i_weights   (r_weights),
            .i_sweep     (r_clr_busy),
            .i_sweep_row (r_clr_row),
            .o_acc       (lane_acc[p])
        );
    end

    gdwa_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_push),
        .i_data  (read_val),
        .o_count (fifo_count),
        .o_out   (o_out)
    );

    // No beat may be taken while the banks are being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("input beat accepted during clearing pass");

    // Every accepted read beat queues exactly one result in the next cycle.
    a_read_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.kind == gdwa_pkg::KIND_READ)) |=> s1_push)
        else $error("read beat did not queue a result");

    // The result queue never overflows.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_push && !(o_out.valid && o_out.ready))
            |-> (fifo_count < gdwa_pkg::OUT_CNT_W'(gdwa_pkg::OUT_DEPTH)))
        else $error("result queue overflow");

endmodule

@@ tb/tb_genotype_dosage_weighted_accumulate.sv @@
// Self-checking testbench for the genotype dosage weighted accumulator.
// Uses gdwa_pkg and gdwa_if and drives genotype_dosage_weighted_accumulate.
// A directed table runs first, then random phases checked by a score predictor.
module tb_genotype_dosage_weighted_accumulate;
    timeunit 1ns;
    timeprecision 1ps;

    // The kind code that the block leaves unused; such a beat must change nothing.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int SUBJECTS        = 4096;
    localparam int COLUMNS         = 4;
    // Genotype and read beats of the random part mostly stay in this many bytes,
    // so that reads land on accumulators that have actually been built up.
    localparam int FOCUS_BYTES     = 16;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BEATS     = 84;
    // Cycles allowed for a beat that makes no result to drain out of the pipeline.
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;
    // A short run of back-to-back genotype beats on the same byte, so that every
    // beat reads the row that the one before it has just written.
    localparam int GENO_REPS       = 12;

    localparam longint SCORE_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SCORE_LO = -SCORE_HI - 1;

    typedef struct {
        logic [1:0]      kind;
        logic [9:0]      byte_index;
        logic [7:0]      genotype_byte;
        logic [1:0]      column;
        gdwa_pkg::t_wgt  weight;
        logic [11:0]     subject;
        logic            clear_after_read;
    } t_beat;

    // One row of the directed table: either a subject count write or a beat that is
    // sent reps times in a row; typed rows carry a score read straight off the spec.
    typedef struct {
        bit              set_count;
        logic [12:0]     count_val;
        t_beat           beat;
        int              reps;
        bit              typed;
        gdwa_pkg::t_acc  typed_score;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [gdwa_pkg::CNT_W-1:0] i_cfg_wdata;

    gdwa_in_if  in_ch ();
    gdwa_out_if out_ch ();

    genotype_dosage_weighted_accumulate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // Predictor state: one accumulator per subject and column, the current
    // variant's weights, and the live subject count.
    longint          score_bank [0:SUBJECTS-1][0:COLUMNS-1];
    gdwa_pkg::t_wgt  col_weight [0:COLUMNS-1];
    logic [12:0]     live_count;

    gdwa_pkg::t_acc  pending_scores [$];
    t_dir_row        directed_rows [$];
    int              mismatch_count;
    int              cycle_count;
    bit              hold_off_request;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clamp_add(input longint acc, input longint delta);
        longint s;
        s = acc + delta;
        if (s > SCORE_HI) begin
            s = SCORE_HI;
        end else if (s < SCORE_LO) begin
            s = SCORE_LO;
        end
        return s;
    endfunction

    // Applies one accepted beat to the predictor state. Returns 1 when the beat
    // makes a result, with the expected score in score.
    function automatic bit predict_score(input t_beat b, output gdwa_pkg::t_acc score);
        int     subj;
        longint dose;
        logic [1:0] code;
        score = '0;
        case (b.kind)
            gdwa_pkg::KIND_WEIGHT: begin
                col_weight[b.column] = b.weight;
                return 1'b0;
            end
            gdwa_pkg::KIND_GENO: begin
                for (int p = 0; p < gdwa_pkg::NUM_LANES; p++) begin
                    subj = int'(b.byte_index) * gdwa_pkg::NUM_LANES + p;
                    code = b.genotype_byte[2*p +: 2];
                    // Subjects past the live count are skipped, even inside a byte.
                    if (subj < int'(live_count) && subj < SUBJECTS &&
                        (code == gdwa_pkg::GT_HOM || code == gdwa_pkg::GT_HET)) begin
                        dose = (code == gdwa_pkg::GT_HOM) ? 2 : 1;
                        for (int k = 0; k < COLUMNS; k++) begin
                            score_bank[subj][k] = clamp_add(score_bank[subj][k],
                                                            dose * longint'(col_weight[k]));
                        end
                    end
                end
                return 1'b0;
            end
            gdwa_pkg::KIND_READ: begin
                score = gdwa_pkg::t_acc'(score_bank[b.subject][b.column]);
                if (b.clear_after_read) begin
                    score_bank[b.subject][b.column] = 0;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_cycles(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Random beat: every field is random, then a genotype byte index or read subject is
    // steered toward the focus window so that reads find built-up scores.
    function automatic t_beat random_beat();
        t_beat b;
        int    r;
        b.kind             = 2'($urandom);
        b.byte_index       = 10'($urandom);
        b.genotype_byte    = 8'($urandom);
        b.column           = 2'($urandom);
        b.weight           = gdwa_pkg::t_wgt'($urandom);
        b.subject          = 12'($urandom);
        b.clear_after_read = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 4) begin
            b.kind = KIND_UNUSED;
        end else if (r < 28) begin
            b.kind = gdwa_pkg::KIND_WEIGHT;
            r = $urandom_range(0, 9);
            if (r == 0) begin
                b.weight = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end else if (r < 3) begin
                // Small weights of a few units in Q16.16.
                b.weight = gdwa_pkg::t_wgt'($urandom_range(0, 1 << 19)) - (1 << 18);
            end
        end else if (r < 62) begin
            b.kind = gdwa_pkg::KIND_GENO;
            if ($urandom_range(0, 7) != 0) begin
                b.byte_index = 10'($urandom_range(0, FOCUS_BYTES - 1));
            end
        end else begin
            b.kind = gdwa_pkg::KIND_READ;
            if ($urandom_range(0, 7) != 0) begin
                b.subject = 12'($urandom_range(0, gdwa_pkg::NUM_LANES * FOCUS_BYTES - 1));
            end
            b.clear_after_read = ($urandom_range(0, 3) == 0);
        end
        return b;
    endfunction

    function automatic t_dir_row table_row(input bit set_count, input logic [12:0] count_val,
                                           input logic [1:0] kind, input logic [9:0] idx,
                                           input logic [7:0] gbyte, input logic [1:0] col,
                                           input gdwa_pkg::t_wgt w, input logic [11:0] subj,
                                           input logic clr, input int reps,
                                           input bit typed, input gdwa_pkg::t_acc score);
        t_dir_row row;
        row.set_count              = set_count;
        row.count_val              = count_val;
        row.beat.kind              = kind;
        row.beat.byte_index        = idx;
        row.beat.genotype_byte     = gbyte;
        row.beat.column            = col;
        row.beat.weight            = w;
        row.beat.subject           = subj;
        row.beat.clear_after_read  = clr;
        row.reps                   = reps;
        row.typed                  = typed;
        row.typed_score            = score;
        return row;
    endfunction

    // Offers one beat, starting at the current rising edge, and holds it until the
    // block takes it. The predictor runs on the edge of acceptance.
    task automatic drive_beat(input t_beat b, input bit typed,
                              input gdwa_pkg::t_acc typed_score);
        gdwa_pkg::t_acc score;
        in_ch.valid            <= 1'b1;
        in_ch.kind             <= b.kind;
        in_ch.byte_index       <= b.byte_index;
        in_ch.genotype_byte    <= b.genotype_byte;
        in_ch.column           <= b.column;
        in_ch.weight           <= b.weight;
        in_ch.subject          <= b.subject;
        in_ch.clear_after_read <= b.clear_after_read;
        do @(posedge i_clk); while (!in_ch.ready);
        if (predict_score(b, score)) begin
            pending_scores.push_back(typed ? typed_score : score);
        end
    endtask

    // The subject count may only change while the block is idle, so wait for
    // every read to come back and the last non-reading beats to drain.
    task automatic write_count(input logic [12:0] value);
        in_ch.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        live_count = value;
    endtask

    task automatic idle_sender(input bit quiet);
        int n;
        n = idle_cycles(quiet);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Directed stimulus. A full-scale positive weight in column 0, the most
    // negative one in column 1 and plus and minus one in columns 2 and 3 are
    // added to the first four subjects over a back-to-back run of beats.
    // The byte 8'hE4 holds the four codes in order: two copies, missing, one
    // copy, and the code that counts nothing. A count of 4094 cuts the last byte
    // in half, and a count of zero stops all accumulation.
    task automatic fill_directed();
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 0, 0, 0, 0,
                                          1, 1, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 3, 0, 4095, 1,
                                          1, 1, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_WEIGHT, 0, 0, 0,
                                          32'sh7FFF_FFFF, 0, 0, 1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_WEIGHT, 0, 0, 1,
                                          32'sh8000_0000, 0, 0, 1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_WEIGHT, 0, 0, 2,
                                          32'sh0001_0000, 0, 0, 1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_WEIGHT, 0, 0, 3,
                                          32'shFFFF_0000, 0, 0, 1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_GENO, 0, 8'h00, 0, 0, 0, 0,
                                          GENO_REPS, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 0, 0, 0, 0,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 1, 0, 3, 1,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 1, 0, 3, 0,
                                          1, 1, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 2, 0, 1, 0,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_GENO, 1023, 8'hE4, 0, 0, 0, 0,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 0, 0, 4092, 0,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 0, 0, 4093, 0,
                                          1, 1, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 3, 0, 4094, 0,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 3, 0, 4095, 0,
                                          1, 1, '0));
        directed_rows.push_back(table_row(0, 0, KIND_UNUSED, 10'h3FF, 8'hFF, 2'h3,
                                          32'shFFFF_FFFF, 12'hFFF, 1, 1, 0, '0));
        directed_rows.push_back(table_row(1, 13'd4094, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_GENO, 1023, 8'h00, 0, 0, 0, 0,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 2, 0, 4093, 1,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 2, 0, 4094, 0,
                                          1, 0, '0));
        directed_rows.push_back(table_row(1, 13'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_GENO, 0, 8'h00, 0, 0, 0, 0,
                                          1, 0, '0));
        directed_rows.push_back(table_row(0, 0, gdwa_pkg::KIND_READ, 0, 0, 2, 0, 2, 0,
                                          1, 0, '0));
    endtask

    // Result checker: every score beat is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_scores.size() == 0) begin
                mismatch_count++;
                $display("%0t: score_sum beat %0d arrived with nothing expected",
                         $time, out_ch.score_sum);
            end else if (out_ch.score_sum !== pending_scores[0]) begin
                mismatch_count++;
                $display("%0t: score_sum expected %0d, actual %0d",
                         $time, pending_scores[0], out_ch.score_sum);
                void'(pending_scores.pop_front());
            end else begin
                void'(pending_scores.pop_front());
            end
        end
    end

    // Receiver: random stalls, long ready stretches now and then, and one long
    // hold-off on request that fills the result queue and backs up the input.
    initial begin
        int n;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            n = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
            repeat (n) @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                n = idle_cycles(1'b0);
                if (n > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_dir_row    row;
        bit          quiet;
        logic [12:0] phase_counts [0:RANDOM_PHASES-1];

        in_ch.valid            = 1'b0;
        in_ch.kind             = '0;
        in_ch.byte_index       = '0;
        in_ch.genotype_byte    = '0;
        in_ch.column           = '0;
        in_ch.weight           = '0;
        in_ch.subject          = '0;
        in_ch.clear_after_read = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_wdata            = '0;
        i_rst_n                = 1'b0;
        mismatch_count         = 0;
        hold_off_request       = 1'b0;

        for (int s = 0; s < SUBJECTS; s++) begin
            for (int k = 0; k < COLUMNS; k++) begin
                score_bank[s][k] = 0;
            end
        end
        for (int k = 0; k < COLUMNS; k++) begin
            col_weight[k] = '0;
        end
        live_count = 13'd4096;

        // Subject counts of the random phases: both ends of the legal range, the
        // out-of-range values the block takes as written, and partial last bytes.
        phase_counts[0] = 13'd4096;
        phase_counts[1] = 13'd1;
        phase_counts[2] = 13'd8191;
        phase_counts[3] = 13'd0;
        phase_counts[4] = 13'd37;
        phase_counts[5] = 13'($urandom_range(2, 4095));
        phase_counts[6] = 13'd4093;
        phase_counts[7] = 13'd4096;

        fill_directed();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first beat simply waits out the clearing pass behind in_ch.ready.
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.set_count) begin
                write_count(row.count_val);
            end else begin
                for (int n = 0; n < row.reps; n++) begin
                    drive_beat(row.beat, row.typed, row.typed_score);
                    idle_sender(row.reps > 1);
                end
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_count(phase_counts[ph]);
            // Ask the receiver for its long hold-off while beats keep coming.
            if (ph == 1) begin
                hold_off_request = 1'b1;
            end
            quiet = 1'b0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (n % 20 == 0) begin
                    quiet = ($urandom_range(0, 3) == 0);
                end
                drive_beat(random_beat(), 1'b0, '0);
                idle_sender(quiet);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/gdwa_pkg.sv
hw/rtl/gdwa_if.sv
hw/rtl/gdwa_bank.sv
hw/rtl/gdwa_lane.sv
hw/rtl/gdwa_out_fifo.sv
hw/rtl/genotype_dosage_weighted_accumulate.sv
tb/tb_genotype_dosage_weighted_accumulate.sv
